// ===== design/mscs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the MIPS subset core.
package mscs_pkg;

  localparam int CMD_W      = 2;
  localparam int MADDR_W    = 13;
  localparam int RIDX_W     = 5;
  localparam int HW_W       = 16;
  localparam int WORD_W     = 32;
  localparam int PC_OUT_W   = 13;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W  = OUT_TDATA_W - WORD_W - PC_OUT_W - 1;

  localparam logic [CMD_W-1:0] CMD_WR_MEM = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RD_MEM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RD_REG = 2'd2;
  localparam logic [CMD_W-1:0] CMD_EXEC   = 2'd3;

  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;
  localparam logic [5:0] FN_ADD   = 6'd32;
  localparam logic [5:0] FN_SUB   = 6'd34;

  typedef struct packed {
    logic              en;
    logic [RIDX_W-1:0] idx;
    logic [WORD_W-1:0] data;
  } rf_wr_t;

endpackage

// ===== design/mips_subset_core_step_top.sv =====
`timescale 1ns / 1ps
// MIPS subset core: command sequencer over a halfword memory and a register file.
//
// Input channel (in_*): one request per command. in_tuser carries the command
// (write memory halfword, read memory halfword, read register, execute one
// instruction); in_tdata carries the address, register index and write data.
// Output channel (out_*): exactly one result per request, in order: read value,
// program counter after the request, and the bad-opcode flag.
// States from accept to out_tvalid: memory write goes straight to DONE, memory or
// register read passes RDW, execute passes F1 and EX, lw adds L1 and L2 and sw
// adds S1. The state sequence is set by the single memory port: two fetch reads,
// then up to two data accesses, each with registered read data. One request is
// in work at a time; a new one is accepted only once the sequencer is in IDLE.
// The output register holds a finished result while out_tready is low; the
// sequencer waits in its last state and in_tready stays low until it drains.
// Reset clears the PC, the register file (through per-register valid bits) and
// the output valid flag. Memory contents are undefined until written.
// MEM_HALFWORDS must be a power of two; all addresses wrap modulo it.
module mips_subset_core_step_top
  import mscs_pkg::*;
#(
  parameter int MEM_HALFWORDS = 8192
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [12:0] mem_address, [17:13] reg_index, [33:18] write_halfword
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] command
  input  logic [CMD_W-1:0]       in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] read_value, [44:32] program_counter, [45] bad_opcode
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(MEM_HALFWORDS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDW  = 3'd1;
  localparam logic [2:0] S_F1   = 3'd2;
  localparam logic [2:0] S_EX   = 3'd3;
  localparam logic [2:0] S_L1   = 3'd4;
  localparam logic [2:0] S_L2   = 3'd5;
  localparam logic [2:0] S_S1   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]             state_r, state_nxt;
  logic [CMD_W-1:0]       cmd_r, cmd_nxt;
  logic [WORD_W-1:0]      value_r, value_nxt;
  logic                   bad_r, bad_nxt;
  logic [AW-1:0]          pc_r, pc_nxt;
  logic [HW_W-1:0]        hi_r, hi_nxt;
  logic [AW-1:0]          addr_r, addr_nxt;
  logic [RIDX_W-1:0]      rt_r, rt_nxt;
  logic [HW_W-1:0]        stdata_r, stdata_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic [CMD_W-1:0]   in_cmd;
  logic [MADDR_W-1:0] in_maddr;
  logic [RIDX_W-1:0]  in_ridx;
  logic [HW_W-1:0]    in_wval;
  logic               in_acc;

  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [HW_W-1:0]    mem_wdata;
  logic [HW_W-1:0]    mem_rdata;

  logic [RIDX_W-1:0]  ra_addr, rb_addr;
  logic [WORD_W-1:0]  rs_val, rt_val;
  rf_wr_t             rf_wr;

  logic [WORD_W-1:0]  ir;
  logic [5:0]         op, fn;
  logic [RIDX_W-1:0]  rd, rt;
  logic [WORD_W-1:0]  simm;
  logic [WORD_W-1:0]  ea;
  logic [AW-1:0]      pc_plus2;

  assign in_cmd   = in_tuser;
  assign in_maddr = in_tdata[12:0];
  assign in_ridx  = in_tdata[17:13];
  assign in_wval  = in_tdata[33:18];

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  assign ir       = {hi_r, mem_rdata};
  assign op       = ir[31:26];
  assign rt       = ir[20:16];
  assign rd       = ir[15:11];
  assign fn       = ir[5:0];
  assign simm     = {{HW_W{ir[15]}}, ir[15:0]};
  assign ea       = rs_val + simm;
  assign pc_plus2 = pc_r + AW'(2);

  mscs_hwmem #(.AW(AW)) u_hwmem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  mscs_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (rs_val),
    .rb_data (rt_val),
    .wr      (rf_wr)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    value_nxt     = value_r;
    bad_nxt       = bad_r;
    pc_nxt        = pc_r;
    hi_nxt        = hi_r;
    addr_nxt      = addr_r;
    rt_nxt        = rt_r;
    stdata_nxt    = stdata_r;
    out_valid_nxt = out_valid_r;
    out_tdata_nxt = out_tdata_r;
    mem_we        = 1'b0;
    mem_addr      = pc_r;
    mem_wdata     = in_wval;
    ra_addr       = in_ridx;
    rb_addr       = in_ridx;
    rf_wr.en      = 1'b0;
    rf_wr.idx     = rd;
    rf_wr.data    = rs_val + rt_val;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        // fetch of the first halfword starts in the accept cycle
        mem_addr = (in_cmd == CMD_EXEC) ? pc_r : AW'(in_maddr);
        if (in_acc) begin
          cmd_nxt   = in_cmd;
          value_nxt = '0;
          bad_nxt   = 1'b0;
          case (in_cmd)
            CMD_WR_MEM: begin
              mem_we    = 1'b1;
              state_nxt = S_DONE;
            end
            CMD_RD_MEM, CMD_RD_REG: state_nxt = S_RDW;
            CMD_EXEC:               state_nxt = S_F1;
            default:                state_nxt = S_IDLE;
          endcase
        end
      end
      S_RDW: begin
        value_nxt = (cmd_r == CMD_RD_MEM) ? WORD_W'(mem_rdata) : rs_val;
        state_nxt = S_DONE;
      end
      S_F1: begin
        mem_addr  = pc_r + AW'(1);
        hi_nxt    = mem_rdata;
        ra_addr   = mem_rdata[9:5];
        rb_addr   = mem_rdata[4:0];
        state_nxt = S_EX;
      end
      S_EX: begin
        pc_nxt    = pc_plus2;
        state_nxt = S_DONE;
        case (op)
          OP_RTYPE: begin
            rf_wr.en   = (fn == FN_ADD) || (fn == FN_SUB);
            rf_wr.data = (fn == FN_SUB) ? (rs_val - rt_val) : (rs_val + rt_val);
          end
          OP_LW: begin
            mem_addr  = ea[AW-1:0];
            addr_nxt  = ea[AW-1:0];
            rt_nxt    = rt;
            state_nxt = S_L1;
          end
          OP_SW: begin
            mem_we     = 1'b1;
            mem_addr   = ea[AW-1:0];
            mem_wdata  = rt_val[31:16];
            addr_nxt   = ea[AW-1:0];
            stdata_nxt = rt_val[15:0];
            state_nxt  = S_S1;
          end
          OP_BEQ: begin
            if (rs_val == rt_val) begin
              pc_nxt = pc_plus2 + {simm[AW-2:0], 1'b0};
            end
          end
          OP_J: begin
            pc_nxt = {ir[AW-2:0], 1'b0};
          end
          default: bad_nxt = 1'b1;
        endcase
      end
      S_L1: begin
        mem_addr  = addr_r + AW'(1);
        hi_nxt    = mem_rdata;
        state_nxt = S_L2;
      end
      S_L2: begin
        rf_wr.en   = 1'b1;
        rf_wr.idx  = rt_r;
        rf_wr.data = ir;
        state_nxt  = S_DONE;
      end
      S_S1: begin
        mem_we    = 1'b1;
        mem_addr  = addr_r + AW'(1);
        mem_wdata = stdata_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = {{OUT_PAD_W{1'b0}}, bad_r, PC_OUT_W'(pc_r), value_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    value_r     <= value_nxt;
    bad_r       <= bad_nxt;
    hi_r        <= hi_nxt;
    addr_r      <= addr_nxt;
    rt_r        <= rt_nxt;
    stdata_r    <= stdata_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule

// ===== design/mscs_hwmem.sv =====
`timescale 1ns / 1ps
// Single-port halfword memory with registered read data.
module mscs_hwmem
  import mscs_pkg::*;
#(
  parameter int AW = 13
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   addr,
  input  logic [HW_W-1:0] wdata,
  output logic [HW_W-1:0] rdata
);

  logic [HW_W-1:0] mem [2**AW];
  logic [HW_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/mscs_regfile.sv =====
`timescale 1ns / 1ps
// 32 x 32 register file, two registered read ports, valid bits for reset-to-zero.
module mscs_regfile
  import mscs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [RIDX_W-1:0] ra_addr,
  input  logic [RIDX_W-1:0] rb_addr,
  output logic [WORD_W-1:0] ra_data,
  output logic [WORD_W-1:0] rb_data,
  input  rf_wr_t            wr
);

  localparam int NREG = 2**RIDX_W;

  logic [WORD_W-1:0] mem [NREG];
  logic [NREG-1:0]   vld_r;
  logic [NREG-1:0]   vld_nxt;
  logic [WORD_W-1:0] ra_raw_r;
  logic [WORD_W-1:0] rb_raw_r;
  logic              ra_vld_r;
  logic              rb_vld_r;
  logic              wr_ok;

  // register zero is never written, so it stays invalid and reads zero
  assign wr_ok = wr.en && (wr.idx != '0);

  always_comb begin
    vld_nxt = vld_r;
    if (wr_ok) begin
      vld_nxt[wr.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr.idx] <= wr.data;
    end
    ra_raw_r <= mem[ra_addr];
    rb_raw_r <= mem[rb_addr];
    ra_vld_r <= vld_r[ra_addr];
    rb_vld_r <= vld_r[rb_addr];
  end

  assign ra_data = ra_vld_r ? ra_raw_r : '0;
  assign rb_data = rb_vld_r ? rb_raw_r : '0;

endmodule
